// File: rtl/madp_pkg.sv
// Package for the motion adaptive deinterlacer: register indexes, reset values,
// field widths, the request and configuration structs and small helper functions.
// Used by the interfaces, the datapath, the top level and the checker.
package madp_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PairW  = 16;
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 14;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CoefShift = 13;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_USE_ALT   = 4'd0,
    CFG_SP_NEAR   = 4'd1,
    CFG_SP_FAR    = 4'd2,
    CFG_LF_NEAR   = 4'd3,
    CFG_LF_FAR    = 4'd4,
    CFG_HF_CENTER = 4'd5,
    CFG_HF_MID    = 4'd6,
    CFG_HF_OUTER  = 4'd7
  } cfg_reg_e;

  // Row classes. The fourth code behaves like an edge row without spatial check.
  typedef enum logic [KindW-1:0] {
    ROW_INTERIOR     = 2'd0,
    ROW_EDGE_SPATIAL = 2'd1,
    ROW_EDGE_PLAIN   = 2'd2
  } row_kind_e;

  // Reset values of the filter weights.
  localparam logic [CoefW-1:0] SpNearRst   = 14'd5077;
  localparam logic [CoefW-1:0] SpFarRst    = 14'd981;
  localparam logic [CoefW-1:0] LfNearRst   = 14'd4309;
  localparam logic [CoefW-1:0] LfFarRst    = 14'd213;
  localparam logic [CoefW-1:0] HfCenterRst = 14'd5570;
  localparam logic [CoefW-1:0] HfMidRst    = 14'd3801;
  localparam logic [CoefW-1:0] HfOuterRst  = 14'd1016;

  typedef struct packed {
    logic             use_alt;
    logic [CoefW-1:0] sp_near_coef;
    logic [CoefW-1:0] sp_far_coef;
    logic [CoefW-1:0] lf_near_coef;
    logic [CoefW-1:0] lf_far_coef;
    logic [CoefW-1:0] hf_center_coef;
    logic [CoefW-1:0] hf_mid_coef;
    logic [CoefW-1:0] hf_outer_coef;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] row_kind;
    logic [PairW-1:0] temporal_center;
    logic [PairW-1:0] temporal_up2;
    logic [PairW-1:0] temporal_down2;
    logic [PairW-1:0] temporal_up4;
    logic [PairW-1:0] temporal_down4;
    logic [PairW-1:0] prev_pair;
    logic [PairW-1:0] next_pair;
    logic [PairW-1:0] cur_inner;
    logic [PairW-1:0] cur_outer;
    logic [PixW-1:0]  alt_pixel;
  } pix_req_t;

  // Absolute difference of two pixels.
  function automatic logic [PixW-1:0] abs_diff(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [PixW-1:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  // Sum of two pixels, one bit wider.
  function automatic logic [PixW:0] add2(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [PixW:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r;
  endfunction

endpackage

// File: rtl/madp_if.sv
// Channel interfaces of the deinterlacer: pixel request, pixel response and
// configuration write. Depends on madp_pkg for the field widths.
interface madp_req_if;
  import madp_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] row_kind;
  logic [PairW-1:0] temporal_center;
  logic [PairW-1:0] temporal_up2;
  logic [PairW-1:0] temporal_down2;
  logic [PairW-1:0] temporal_up4;
  logic [PairW-1:0] temporal_down4;
  logic [PairW-1:0] prev_pair;
  logic [PairW-1:0] next_pair;
  logic [PairW-1:0] cur_inner;
  logic [PairW-1:0] cur_outer;
  logic [PixW-1:0]  alt_pixel;

  modport source (
    output valid, row_kind, temporal_center, temporal_up2, temporal_down2,
           temporal_up4, temporal_down4, prev_pair, next_pair, cur_inner,
           cur_outer, alt_pixel,
    input  ready
  );
  modport sink (
    input  valid, row_kind, temporal_center, temporal_up2, temporal_down2,
           temporal_up4, temporal_down4, prev_pair, next_pair, cur_inner,
           cur_outer, alt_pixel,
    output ready
  );
endinterface

interface madp_rsp_if;
  import madp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink   (input valid, out_pixel, output ready);
endinterface

interface madp_cfg_if;
  import madp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/madp_datapath.sv
// Five-stage arithmetic pipeline of the deinterlacer: bound, products, sums,
// interpolation select and final clamp. Depends on madp_pkg.
module madp_datapath #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  madp_pkg::cfg_t         cfg_i,
  input  madp_pkg::pix_req_t     req_i,
  output logic [madp_pkg::PixW-1:0] out_pixel_o
);
  import madp_pkg::*;

  localparam int unsigned PeakW = (PIXEL_BITS > 10) ? PIXEL_BITS : 10;
  localparam logic [PeakW-1:0] Peak = PeakW'((64'd1 << PIXEL_BITS) - 64'd1);

  // ---------------- Stage 1: unpack, temporal bound terms and tap sums.
  logic [PixW-1:0] p2, n2, p2u2, n2u2, p2d2, n2d2, p2u4, n2u4, p2d4, n2d4;
  logic [PixW-1:0] pa, pb, na, nb, c, e, c3, e3;
  logic [PixW:0]   sum_c, sum_td1, sum_td2, sum_up, sum_dn;
  logic [PixW-1:0] d1, up_mean, dn_mean;

  logic [KindW-1:0]  kind1_q;
  logic [PixW-1:0]   d1_q, td0_q, td1_q, td2_q, alt1_q;
  logic signed [9:0] b_q, f_q, dc_q, de_q;
  logic [PixW:0]     sc_q, ce1_q, ce3_q;
  logic [PixW+1:0]   smid_q, sout_q;
  logic              hf_sel1_q;

  always_comb begin
    {n2, p2}     = req_i.temporal_center;
    {n2u2, p2u2} = req_i.temporal_up2;
    {n2d2, p2d2} = req_i.temporal_down2;
    {n2u4, p2u4} = req_i.temporal_up4;
    {n2d4, p2d4} = req_i.temporal_down4;
    {pb, pa}     = req_i.prev_pair;
    {nb, na}     = req_i.next_pair;
    {e, c}       = req_i.cur_inner;
    {e3, c3}     = req_i.cur_outer;
    sum_c   = add2(p2, n2);
    sum_td1 = add2(abs_diff(pa, c), abs_diff(pb, e));
    sum_td2 = add2(abs_diff(na, c), abs_diff(nb, e));
    sum_up  = add2(p2u2, n2u2);
    sum_dn  = add2(p2d2, n2d2);
    d1      = sum_c[PixW:1];
    up_mean = sum_up[PixW:1];
    dn_mean = sum_dn[PixW:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q   <= req_i.row_kind;
      alt1_q    <= req_i.alt_pixel;
      d1_q      <= d1;
      td0_q     <= abs_diff(p2, n2);
      td1_q     <= sum_td1[PixW:1];
      td2_q     <= sum_td2[PixW:1];
      b_q       <= $signed({2'b00, up_mean}) - $signed({2'b00, c});
      f_q       <= $signed({2'b00, dn_mean}) - $signed({2'b00, e});
      dc_q      <= $signed({2'b00, d1}) - $signed({2'b00, c});
      de_q      <= $signed({2'b00, d1}) - $signed({2'b00, e});
      sc_q      <= sum_c;
      smid_q    <= {1'b0, sum_up} + {1'b0, sum_dn};
      sout_q    <= {1'b0, add2(p2u4, n2u4)} + {1'b0, add2(p2d4, n2d4)};
      ce1_q     <= add2(c, e);
      ce3_q     <= add2(c3, e3);
      hf_sel1_q <= (abs_diff(c, e) > abs_diff(p2, n2));
    end
  end

  // ---------------- Stage 2: final bound with spatial check, filter products.
  logic [PixW-1:0]   base, diff2;
  logic signed [9:0] mx, mn, neg_mx, widen, base_s;
  logic [CoefW-1:0]  near_coef, far_coef;
  logic              spat;

  logic [KindW-1:0]  kind2_q;
  logic [PixW-1:0]   d2_q, diff2_q, alt2_q;
  logic [PixW:0]     ce2_q;
  logic              hf_sel2_q;
  logic [22:0]       pc_q, pn_q, pf_q;
  logic [23:0]       pm_q, po_q;

  always_comb begin
    base   = (td1_q > td2_q) ? td1_q : td2_q;
    base   = ({1'b0, td0_q[PixW-1:1]} > base) ? {1'b0, td0_q[PixW-1:1]} : base;
    mx     = (de_q > dc_q) ? de_q : dc_q;
    mx     = (((b_q < f_q) ? b_q : f_q) > mx) ? ((b_q < f_q) ? b_q : f_q) : mx;
    mn     = (de_q < dc_q) ? de_q : dc_q;
    mn     = (((b_q > f_q) ? b_q : f_q) < mn) ? ((b_q > f_q) ? b_q : f_q) : mn;
    neg_mx = -mx;
    widen  = (mn > neg_mx) ? mn : neg_mx;
    base_s = $signed({2'b00, base});
    spat   = (kind1_q == ROW_INTERIOR) || (kind1_q == ROW_EDGE_SPATIAL);
    // A zero bound forces the temporal mean, so the clamp window stays closed.
    if (base == '0) begin
      diff2 = '0;
    end else if (spat && (widen > base_s)) begin
      diff2 = widen[PixW-1:0];
    end else begin
      diff2 = base;
    end
    near_coef = hf_sel1_q ? cfg_i.lf_near_coef : cfg_i.sp_near_coef;
    far_coef  = hf_sel1_q ? cfg_i.lf_far_coef : cfg_i.sp_far_coef;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q   <= kind1_q;
      d2_q      <= d1_q;
      diff2_q   <= diff2;
      alt2_q    <= alt1_q;
      ce2_q     <= ce1_q;
      hf_sel2_q <= hf_sel1_q;
      pc_q      <= 23'(cfg_i.hf_center_coef) * 23'(sc_q);
      pm_q      <= 24'(cfg_i.hf_mid_coef) * 24'(smid_q);
      po_q      <= 24'(cfg_i.hf_outer_coef) * 24'(sout_q);
      pn_q      <= 23'(near_coef) * 23'(ce1_q);
      pf_q      <= 23'(far_coef) * 23'(ce3_q);
    end
  end

  // ---------------- Stage 3: high-frequency sum and near/far difference.
  logic [KindW-1:0]   kind3_q;
  logic [PixW-1:0]    d3_q, diff3_q, alt3_q;
  logic [PixW:0]      ce3m_q;
  logic signed [26:0] hf_q;
  logic signed [23:0] nf_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind3_q <= kind2_q;
      d3_q    <= d2_q;
      diff3_q <= diff2_q;
      alt3_q  <= alt2_q;
      ce3m_q  <= ce2_q;
      if (hf_sel2_q) begin
        hf_q <= $signed({4'b0000, pc_q}) - $signed({3'b000, pm_q})
              + $signed({3'b000, po_q});
      end else begin
        hf_q <= '0;
      end
      nf_q <= $signed({1'b0, pn_q}) - $signed({1'b0, pf_q});
    end
  end

  // ---------------- Stage 4: accumulate, scale down and pick the interpolation.
  logic signed [26:0] acc;
  logic signed [13:0] interp4;

  logic [PixW-1:0]    d4_q, diff4_q;
  logic signed [13:0] interp4_q;

  always_comb begin
    acc = (hf_q >>> 2) + $signed({{3{nf_q[23]}}, nf_q});
    if (cfg_i.use_alt) begin
      interp4 = $signed({6'b000000, alt3_q});
    end else if (kind3_q == ROW_INTERIOR) begin
      interp4 = acc[26:CoefShift];
    end else begin
      interp4 = $signed({6'b000000, ce3m_q[PixW:1]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d4_q      <= d3_q;
      diff4_q   <= diff3_q;
      interp4_q <= interp4;
    end
  end

  // ---------------- Stage 5: clamp to the temporal window, then to the pixel range.
  logic signed [10:0] lo, hi, win;
  logic signed [13:0] clip;
  logic [PixW-1:0]    pix5;

  always_comb begin
    lo = $signed({3'b000, d4_q}) - $signed({3'b000, diff4_q});
    hi = $signed({3'b000, d4_q}) + $signed({3'b000, diff4_q});
    if (interp4_q < $signed({{3{lo[10]}}, lo})) begin
      clip = $signed({{3{lo[10]}}, lo});
    end else if (interp4_q > $signed({{3{hi[10]}}, hi})) begin
      clip = $signed({{3{hi[10]}}, hi});
    end else begin
      clip = interp4_q;
    end
    win = clip[10:0];
    if (win[10]) begin
      pix5 = '0;
    end else if (PeakW'(win[9:0]) > Peak) begin
      pix5 = Peak[PixW-1:0];
    end else begin
      pix5 = win[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_pixel_o <= pix5;
    end
  end

endmodule

// File: rtl/motion_adaptive_deinterlace_pixel_top.sv
// Motion adaptive deinterlacer, one missing-line pixel per request.
// Each request passes through the five register stages of the datapath (bound,
// products, sums, select, clamp) to the output; a new request can enter every
// cycle while the output is not stalled, and a stalled output holds the whole
// pipeline. Configuration writes take effect at once and are accepted every cycle.
// Depends on madp_pkg, the channel interfaces and madp_datapath.
module motion_adaptive_deinterlace_pixel_top #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  madp_cfg_if.sink   cfg_i,
  madp_req_if.sink   req_i,
  madp_rsp_if.source rsp_o
);
  import madp_pkg::*;

  localparam int unsigned Stages = 5;

  cfg_t              cfg_q;
  pix_req_t          req;
  logic [Stages-1:0] valid_q;
  logic              advance;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_alt        <= 1'b0;
      cfg_q.sp_near_coef   <= SpNearRst;
      cfg_q.sp_far_coef    <= SpFarRst;
      cfg_q.lf_near_coef   <= LfNearRst;
      cfg_q.lf_far_coef    <= LfFarRst;
      cfg_q.hf_center_coef <= HfCenterRst;
      cfg_q.hf_mid_coef    <= HfMidRst;
      cfg_q.hf_outer_coef  <= HfOuterRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_USE_ALT:   cfg_q.use_alt        <= cfg_i.data[0];
        CFG_SP_NEAR:   cfg_q.sp_near_coef   <= cfg_i.data[CoefW-1:0];
        CFG_SP_FAR:    cfg_q.sp_far_coef    <= cfg_i.data[CoefW-1:0];
        CFG_LF_NEAR:   cfg_q.lf_near_coef   <= cfg_i.data[CoefW-1:0];
        CFG_LF_FAR:    cfg_q.lf_far_coef    <= cfg_i.data[CoefW-1:0];
        CFG_HF_CENTER: cfg_q.hf_center_coef <= cfg_i.data[CoefW-1:0];
        CFG_HF_MID:    cfg_q.hf_mid_coef    <= cfg_i.data[CoefW-1:0];
        CFG_HF_OUTER:  cfg_q.hf_outer_coef  <= cfg_i.data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless the output register holds a pixel
  // that the sink has not taken.
  assign advance     = !valid_q[Stages-1] || rsp_o.ready;
  assign req_i.ready = advance;

  // Valid bits travel alongside the datapath stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Stages-2:0], req_i.valid};
    end
  end

  assign rsp_o.valid = valid_q[Stages-1];

  always_comb begin
    req.row_kind        = req_i.row_kind;
    req.temporal_center = req_i.temporal_center;
    req.temporal_up2    = req_i.temporal_up2;
    req.temporal_down2  = req_i.temporal_down2;
    req.temporal_up4    = req_i.temporal_up4;
    req.temporal_down4  = req_i.temporal_down4;
    req.prev_pair       = req_i.prev_pair;
    req.next_pair       = req_i.next_pair;
    req.cur_inner       = req_i.cur_inner;
    req.cur_outer       = req_i.cur_outer;
    req.alt_pixel       = req_i.alt_pixel;
  end

  madp_datapath #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .en_i        (advance),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .out_pixel_o (rsp_o.out_pixel)
  );

endmodule

// File: rtl/madp_checker.sv
// Port-level checks of the deinterlacer top level and the bind that attaches them.
// Depends on madp_pkg for the pixel width.
module madp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [madp_pkg::PixW-1:0] rsp_pixel_i,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_i
);
  import madp_pkg::*;

  // A stalled response keeps its pixel until taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pixel_i))
    else $error("response changed while stalled");

  // Requests are refused only while a finished pixel waits at the output.
  a_req_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!rsp_valid_i || rsp_ready_i))
    else $error("request ready does not follow the output stall");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write refused");

  // No pixel can come out right after reset: the pipeline starts empty.
  a_rst_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !rsp_valid_i ##1 !rsp_valid_i)
    else $error("response valid too soon after reset");

  // A request offered while the output is empty is taken in the same cycle.
  a_req_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !rsp_valid_i |-> req_ready_i)
    else $error("request refused while the output is empty");

endmodule

bind motion_adaptive_deinterlace_pixel_top madp_checker u_madp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_pixel_i (rsp_o.out_pixel),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

// File: sim/madp_pixel_checker.sv
`timescale 1ns / 1ps
// Checker for the deinterlacer: watches the configuration, request and response
// channels, predicts each pixel and compares. Depends on madp_pkg and madp_if.
module madp_pixel_checker #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  madp_cfg_if  cfg_i,
  madp_req_if  req_i,
  madp_rsp_if  rsp_i,
  output int   failures_o,
  output int   pending_o
);
  import madp_pkg::*;

  // Only the first mismatches are printed; all of them are counted.
  localparam int ReportCap = 40;

  cfg_t            weights;
  logic [PixW-1:0] pixels_due[$];
  int unsigned     pixels_seen;

  // Low and high pixel of a packed pair, as signed numbers.
  function automatic longint low_pix(logic [PairW-1:0] v);
    longint r;
    r = 0;
    r[PixW-1:0] = v[PixW-1:0];
    return r;
  endfunction

  function automatic longint high_pix(logic [PairW-1:0] v);
    longint r;
    r = 0;
    r[PixW-1:0] = v[PairW-1:PixW];
    return r;
  endfunction

  function automatic longint weight(logic [CoefW-1:0] v);
    longint r;
    r = 0;
    r[CoefW-1:0] = v;
    return r;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint larger(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint smaller(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Missing-line pixel for one request under the given register settings.
  function automatic logic [PixW-1:0] predict_pixel(pix_req_t r, cfg_t w);
    longint p2, n2, pu2, nu2, pd2, nd2, pu4, nu4, pd4, nd4;
    longint pa, pb, na, nb, c, e, c3, e3, alt;
    longint mean, tdiff, prev_d, next_d, bound;
    longint above, below, hi_lim, lo_lim, hf, acc, interp, peak;
    logic   spatial;
    p2  = low_pix(r.temporal_center);  n2  = high_pix(r.temporal_center);
    pu2 = low_pix(r.temporal_up2);     nu2 = high_pix(r.temporal_up2);
    pd2 = low_pix(r.temporal_down2);   nd2 = high_pix(r.temporal_down2);
    pu4 = low_pix(r.temporal_up4);     nu4 = high_pix(r.temporal_up4);
    pd4 = low_pix(r.temporal_down4);   nd4 = high_pix(r.temporal_down4);
    pa  = low_pix(r.prev_pair);        pb  = high_pix(r.prev_pair);
    na  = low_pix(r.next_pair);        nb  = high_pix(r.next_pair);
    c   = low_pix(r.cur_inner);        e   = high_pix(r.cur_inner);
    c3  = low_pix(r.cur_outer);        e3  = high_pix(r.cur_outer);
    alt = 0;
    alt[PixW-1:0] = r.alt_pixel;
    peak = (longint'(1) <<< PIXEL_BITS) - 1;

    // Temporal mean and the motion bound around it.
    mean   = (p2 + n2) >>> 1;
    tdiff  = mag(p2 - n2);
    prev_d = (mag(pa - c) + mag(pb - e)) >>> 1;
    next_d = (mag(na - c) + mag(nb - e)) >>> 1;
    bound  = larger(tdiff >>> 1, larger(prev_d, next_d));
    if (bound == 0) begin
      return mean[PixW-1:0];
    end

    // The spatial check may widen the bound.
    spatial = (r.row_kind == ROW_INTERIOR) || (r.row_kind == ROW_EDGE_SPATIAL);
    if (spatial) begin
      above  = ((pu2 + nu2) >>> 1) - c;
      below  = ((pd2 + nd2) >>> 1) - e;
      hi_lim = larger(larger(mean - e, mean - c), smaller(above, below));
      lo_lim = smaller(smaller(mean - e, mean - c), larger(above, below));
      bound  = larger(bound, larger(lo_lim, -hi_lim));
    end

    // Interpolation: alternate pixel, coefficient filters, or vertical mean.
    if (w.use_alt) begin
      interp = alt;
    end else if (r.row_kind == ROW_INTERIOR) begin
      if (mag(c - e) > tdiff) begin
        hf  = weight(w.hf_center_coef) * (p2 + n2)
            - weight(w.hf_mid_coef) * (pu2 + nu2 + pd2 + nd2)
            + weight(w.hf_outer_coef) * (pu4 + nu4 + pd4 + nd4);
        acc = (hf >>> 2) + weight(w.lf_near_coef) * (c + e)
            - weight(w.lf_far_coef) * (c3 + e3);
      end else begin
        acc = weight(w.sp_near_coef) * (c + e) - weight(w.sp_far_coef) * (c3 + e3);
      end
      interp = acc >>> CoefShift;
    end else begin
      interp = (c + e) >>> 1;
    end
    interp = clip(interp, mean - bound, mean + bound);
    interp = clip(interp, 0, peak);
    return interp[PixW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (failures_o < ReportCap) begin
      $display("%0t ns checker: %s", $time, what);
    end
    failures_o++;
  endtask

  // Responses are checked before the request of the same edge is predicted,
  // and a register write only affects later requests.
  always @(posedge clk_i or negedge rst_ni) begin
    pix_req_t        sample;
    logic [PixW-1:0] want;
    if (!rst_ni) begin
      weights = '{use_alt: 1'b0, sp_near_coef: SpNearRst, sp_far_coef: SpFarRst,
                  lf_near_coef: LfNearRst, lf_far_coef: LfFarRst,
                  hf_center_coef: HfCenterRst, hf_mid_coef: HfMidRst,
                  hf_outer_coef: HfOuterRst};
      pixels_due.delete();
      pixels_seen = 0;
      failures_o  = 0;
      pending_o   = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with no request outstanding",
                                    pixels_seen));
        end else begin
          want = pixels_due.pop_front();
          if (rsp_i.out_pixel !== want) begin
            report_mismatch($sformatf("pixel %0d: out_pixel got %0d, expected %0d",
                                      pixels_seen, rsp_i.out_pixel, want));
          end
        end
        pixels_seen++;
      end

      if (req_i.valid && req_i.ready) begin
        sample.row_kind        = req_i.row_kind;
        sample.temporal_center = req_i.temporal_center;
        sample.temporal_up2    = req_i.temporal_up2;
        sample.temporal_down2  = req_i.temporal_down2;
        sample.temporal_up4    = req_i.temporal_up4;
        sample.temporal_down4  = req_i.temporal_down4;
        sample.prev_pair       = req_i.prev_pair;
        sample.next_pair       = req_i.next_pair;
        sample.cur_inner       = req_i.cur_inner;
        sample.cur_outer       = req_i.cur_outer;
        sample.alt_pixel       = req_i.alt_pixel;
        pixels_due.push_back(predict_pixel(sample, weights));
      end

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_USE_ALT:   weights.use_alt        = cfg_i.data[0];
          CFG_SP_NEAR:   weights.sp_near_coef   = cfg_i.data[CoefW-1:0];
          CFG_SP_FAR:    weights.sp_far_coef    = cfg_i.data[CoefW-1:0];
          CFG_LF_NEAR:   weights.lf_near_coef   = cfg_i.data[CoefW-1:0];
          CFG_LF_FAR:    weights.lf_far_coef    = cfg_i.data[CoefW-1:0];
          CFG_HF_CENTER: weights.hf_center_coef = cfg_i.data[CoefW-1:0];
          CFG_HF_MID:    weights.hf_mid_coef    = cfg_i.data[CoefW-1:0];
          CFG_HF_OUTER:  weights.hf_outer_coef  = cfg_i.data[CoefW-1:0];
          default: ;
        endcase
      end

      pending_o = pixels_due.size();
    end
  end

endmodule

// File: sim/motion_adaptive_deinterlace_pixel_top_tb.sv
`timescale 1ns / 1ps
// Top of the deinterlacer testbench: clock, reset, request and register stimulus,
// response stalls and the verdict. Depends on madp_pkg, madp_if and the checker.
module motion_adaptive_deinterlace_pixel_top_tb;
  import madp_pkg::*;

  localparam int unsigned PixelBits   = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongStall   = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RegCount    = 8;
  localparam int          PixMax      = (1 << PixW) - 1;
  localparam logic [CoefW-1:0] CoefMax = '1;
  localparam logic [KindW-1:0] RowUnused = 2'd3;

  // Shapes of random requests and patterns of the response stall.
  typedef enum {GEN_NOISE, GEN_STILL, GEN_SLOW, GEN_EXTREME} gen_mode_e;
  typedef enum {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycles = 0;
  int          failures;
  int          pending;
  logic        long_stall_req = 1'b0;

  madp_cfg_if cfg_bus ();
  madp_req_if req_bus ();
  madp_rsp_if rsp_bus ();

  motion_adaptive_deinterlace_pixel_top #(.PIXEL_BITS(PixelBits)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  madp_pixel_checker #(.PIXEL_BITS(PixelBits)) pixel_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_bus),
    .req_i      (req_bus),
    .rsp_i      (rsp_bus),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic pix_req_t make_item(
    logic [KindW-1:0] kind, logic [PairW-1:0] center, logic [PairW-1:0] up2,
    logic [PairW-1:0] down2, logic [PairW-1:0] up4, logic [PairW-1:0] down4,
    logic [PairW-1:0] prev, logic [PairW-1:0] next, logic [PairW-1:0] inner,
    logic [PairW-1:0] outer, logic [PixW-1:0] alt);
    pix_req_t r;
    r.row_kind        = kind;
    r.temporal_center = center;
    r.temporal_up2    = up2;
    r.temporal_down2  = down2;
    r.temporal_up4    = up4;
    r.temporal_down4  = down4;
    r.prev_pair       = prev;
    r.next_pair       = next;
    r.cur_inner       = inner;
    r.cur_outer       = outer;
    r.alt_pixel       = alt;
    return r;
  endfunction

  // A pixel near base, kept inside the pixel range.
  function automatic logic [PixW-1:0] near_pix(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > PixMax) v = PixMax;
    return v[PixW-1:0];
  endfunction

  function automatic logic [PixW-1:0] extreme_pix();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic pix_req_t random_request();
    pix_req_t        r;
    gen_mode_e       mode;
    int unsigned     pick;
    int              base, spread;
    logic [PixW-1:0] x, c, e;
    pick = $urandom_range(0, 9);
    mode = (pick < 3) ? GEN_NOISE : (pick < 4) ? GEN_STILL :
           (pick < 7) ? GEN_SLOW : GEN_EXTREME;
    r.row_kind = KindW'($urandom_range(0, 3));
    r.alt_pixel = PixW'($urandom);
    case (mode)
      GEN_NOISE: begin
        r.temporal_center = PairW'($urandom); r.temporal_up2   = PairW'($urandom);
        r.temporal_down2  = PairW'($urandom); r.temporal_up4   = PairW'($urandom);
        r.temporal_down4  = PairW'($urandom); r.prev_pair      = PairW'($urandom);
        r.next_pair       = PairW'($urandom); r.cur_inner      = PairW'($urandom);
        r.cur_outer       = PairW'($urandom);
      end
      GEN_STILL: begin
        // No motion at all: the bound is zero and the temporal mean comes out.
        x = PixW'($urandom);
        c = PixW'($urandom);
        e = PixW'($urandom);
        r.temporal_center = {x, x};
        r.prev_pair = {e, c};
        r.next_pair = {e, c};
        r.cur_inner = {e, c};
        r.temporal_up2 = PairW'($urandom); r.temporal_down2 = PairW'($urandom);
        r.temporal_up4 = PairW'($urandom); r.temporal_down4 = PairW'($urandom);
        r.cur_outer = PairW'($urandom);
      end
      GEN_SLOW: begin
        // Small motion around one level, so the clamps and the filters compete.
        base = $urandom_range(0, PixMax);
        case ($urandom_range(0, 2))
          0:       spread = 1;
          1:       spread = 4;
          default: spread = 16;
        endcase
        r.temporal_center = {near_pix(base, spread), near_pix(base, spread)};
        r.temporal_up2    = {near_pix(base, spread), near_pix(base, spread)};
        r.temporal_down2  = {near_pix(base, spread), near_pix(base, spread)};
        r.temporal_up4    = {near_pix(base, spread), near_pix(base, spread)};
        r.temporal_down4  = {near_pix(base, spread), near_pix(base, spread)};
        r.prev_pair       = {near_pix(base, spread), near_pix(base, spread)};
        r.next_pair       = {near_pix(base, spread), near_pix(base, spread)};
        r.cur_inner       = {near_pix(base, 4 * spread), near_pix(base, 4 * spread)};
        r.cur_outer       = {near_pix(base, 4 * spread), near_pix(base, 4 * spread)};
      end
      default: begin
        r.temporal_center = {extreme_pix(), extreme_pix()};
        r.temporal_up2    = {extreme_pix(), extreme_pix()};
        r.temporal_down2  = {extreme_pix(), extreme_pix()};
        r.temporal_up4    = {extreme_pix(), extreme_pix()};
        r.temporal_down4  = {extreme_pix(), extreme_pix()};
        r.prev_pair       = {extreme_pix(), extreme_pix()};
        r.next_pair       = {extreme_pix(), extreme_pix()};
        r.cur_inner       = {extreme_pix(), extreme_pix()};
        r.cur_outer       = {extreme_pix(), extreme_pix()};
        r.alt_pixel       = extreme_pix();
      end
    endcase
    return r;
  endfunction

  function automatic cfg_t uniform_weights(logic alt, logic [CoefW-1:0] coef);
    cfg_t w;
    w.use_alt = alt;
    w.sp_near_coef = coef;   w.sp_far_coef = coef;
    w.lf_near_coef = coef;   w.lf_far_coef = coef;
    w.hf_center_coef = coef; w.hf_mid_coef = coef; w.hf_outer_coef = coef;
    return w;
  endfunction

  function automatic cfg_t random_weights(logic alt);
    cfg_t w;
    w.use_alt        = alt;
    w.sp_near_coef   = CoefW'($urandom);
    w.sp_far_coef    = CoefW'($urandom);
    w.lf_near_coef   = CoefW'($urandom);
    w.lf_far_coef    = CoefW'($urandom);
    w.hf_center_coef = CoefW'($urandom);
    w.hf_mid_coef    = CoefW'($urandom);
    w.hf_outer_coef  = CoefW'($urandom);
    return w;
  endfunction

  // Register word with random bits above the coefficient.
  function automatic logic [CfgDataW-1:0] coef_word(logic [CoefW-1:0] coef);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[CoefW-1:0] = coef;
    return word;
  endfunction

  // Callers are at a falling edge; returns at the falling edge after the write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Loads all registers once the block has drained, plus one unused index.
  task automatic program_weights(input cfg_t w);
    logic [CfgDataW-1:0] word;
    req_bus.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    write_reg(CfgIdxW'($urandom_range(RegCount, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    word = CfgDataW'($urandom);
    word[0] = w.use_alt;
    write_reg(CFG_USE_ALT, word);
    write_reg(CFG_SP_NEAR, coef_word(w.sp_near_coef));
    write_reg(CFG_SP_FAR, coef_word(w.sp_far_coef));
    write_reg(CFG_LF_NEAR, coef_word(w.lf_near_coef));
    write_reg(CFG_LF_FAR, coef_word(w.lf_far_coef));
    write_reg(CFG_HF_CENTER, coef_word(w.hf_center_coef));
    write_reg(CFG_HF_MID, coef_word(w.hf_mid_coef));
    write_reg(CFG_HF_OUTER, coef_word(w.hf_outer_coef));
    cfg_bus.valid = 1'b0;
  endtask

  // Offers one request and holds it until accepted; valid stays high afterwards.
  task automatic offer(input pix_req_t item);
    req_bus.valid           = 1'b1;
    req_bus.row_kind        = item.row_kind;
    req_bus.temporal_center = item.temporal_center;
    req_bus.temporal_up2    = item.temporal_up2;
    req_bus.temporal_down2  = item.temporal_down2;
    req_bus.temporal_up4    = item.temporal_up4;
    req_bus.temporal_down4  = item.temporal_down4;
    req_bus.prev_pair       = item.prev_pair;
    req_bus.next_pair       = item.next_pair;
    req_bus.cur_inner       = item.cur_inner;
    req_bus.cur_outer       = item.cur_outer;
    req_bus.alt_pixel       = item.alt_pixel;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random requests in bursts, with an idle gap after most bursts.
  task automatic run_random(input int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) offer(random_request());
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        req_bus.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    req_bus.valid = 1'b0;
  endtask

  // Response side: stall patterns of random length, and one long hold-off.
  initial begin : response_stall
    rx_mode_e    mode;
    int unsigned span;
    logic        stall_taken;
    mode = RX_OPEN;
    span = 0;
    stall_taken = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        rsp_bus.ready = 1'b0;
        repeat (LongStall) @(negedge clk_i);
      end
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        RX_OPEN:   rsp_bus.ready = 1'b1;
        RX_HALF:   rsp_bus.ready = 1'($urandom_range(0, 1));
        RX_MOSTLY: rsp_bus.ready = ($urandom_range(0, 7) != 0);
        default:   rsp_bus.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    cfg_t w;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    req_bus.valid = 1'b0;
    req_bus.row_kind = '0;
    req_bus.temporal_center = '0; req_bus.temporal_up2 = '0; req_bus.temporal_down2 = '0;
    req_bus.temporal_up4 = '0;    req_bus.temporal_down4 = '0;
    req_bus.prev_pair = '0;       req_bus.next_pair = '0;
    req_bus.cur_inner = '0;       req_bus.cur_outer = '0;
    req_bus.alt_pixel = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests under the reset weights.
    offer(make_item(ROW_INTERIOR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    offer(make_item(ROW_INTERIOR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    // Still picture: the temporal mean passes straight through.
    offer(make_item(ROW_INTERIOR, 16'h6464, 16'h1234, 16'hABCD, 16'h0F0F, 16'hF0F0,
                    16'hC80A, 16'hC80A, 16'hC80A, 16'h5A5A, 8'h33));
    // High-frequency filter path.
    offer(make_item(ROW_INTERIOR, 16'h2080, 16'h4060, 16'h5070, 16'h3030, 16'h9090,
                    16'h1010, 16'hF0F0, 16'hE010, 16'h4080, 8'h55));
    // High-frequency sum negative and not a multiple of four.
    offer(make_item(ROW_INTERIOR, 16'h0000, 16'hFEFF, 16'hFFFF, 16'h0000, 16'h0000,
                    16'h0000, 16'h00FF, 16'hFF00, 16'h8080, 8'h00));
    // Spatial filter with a negative sum.
    offer(make_item(ROW_INTERIOR, 16'h0202, 16'h0303, 16'h0101, 16'h7777, 16'h8888,
                    16'h4040, 16'h0000, 16'h0101, 16'hFFFF, 8'hFF));
    offer(make_item(ROW_INTERIOR, 16'h7070, 16'h6C74, 16'h7268, 16'h7070, 16'h7171,
                    16'h8060, 16'h6A76, 16'h7878, 16'h1010, 8'h80));
    // One item under every row kind, the unused code included.
    offer(make_item(ROW_INTERIOR, 16'h30C0, 16'hA020, 16'h10F0, 16'hFF00, 16'h00FF,
                    16'h4499, 16'h9944, 16'h2DB2, 16'h7E81, 8'hAA));
    offer(make_item(ROW_EDGE_SPATIAL, 16'h30C0, 16'hA020, 16'h10F0, 16'hFF00, 16'h00FF,
                    16'h4499, 16'h9944, 16'h2DB2, 16'h7E81, 8'hAA));
    offer(make_item(ROW_EDGE_PLAIN, 16'h30C0, 16'hA020, 16'h10F0, 16'hFF00, 16'h00FF,
                    16'h4499, 16'h9944, 16'h2DB2, 16'h7E81, 8'hAA));
    offer(make_item(RowUnused, 16'h30C0, 16'hA020, 16'h10F0, 16'hFF00, 16'h00FF,
                    16'h4499, 16'h9944, 16'h2DB2, 16'h7E81, 8'hAA));
    // Edge rows must ignore the far taps.
    offer(make_item(ROW_EDGE_PLAIN, 16'h5060, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                    16'h2040, 16'h6080, 16'h9030, 16'hFFFF, 8'h11));
    offer(make_item(ROW_EDGE_SPATIAL, 16'h5060, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                    16'h2040, 16'h6080, 16'h9030, 16'h0000, 8'h11));
    // Clamps at the top and the bottom of the pixel range.
    offer(make_item(ROW_INTERIOR, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h00FF, 16'hFF00, 16'hFFFF, 16'h0000, 8'hFF));
    offer(make_item(ROW_INTERIOR, 16'h000F, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'hFF00, 16'h00FF, 16'h0000, 16'hFFFF, 8'h00));
    // Alternating bit patterns.
    offer(make_item(ROW_EDGE_SPATIAL, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                    16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55));
    offer(make_item(ROW_INTERIOR, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                    16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
    req_bus.valid = 1'b0;

    // Random traffic; partway the response side holds off while requests pile up.
    run_random(100);
    long_stall_req = 1'b1;
    repeat (40) offer(random_request());
    req_bus.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    run_random(100);

    // Extremes of the weights.
    program_weights(uniform_weights(1'b0, CoefMax));
    run_random(150);
    program_weights(uniform_weights(1'b0, '0));
    run_random(100);

    // Alternate pixel in place of the filters.
    program_weights(random_weights(1'b1));
    offer(make_item(ROW_INTERIOR, 16'h2080, 16'h4060, 16'h5070, 16'h3030, 16'h9090,
                    16'h1010, 16'hF0F0, 16'hE010, 16'h4080, 8'h00));
    offer(make_item(ROW_EDGE_SPATIAL, 16'h2080, 16'h4060, 16'h5070, 16'h3030, 16'h9090,
                    16'h1010, 16'hF0F0, 16'hE010, 16'h4080, 8'hFF));
    offer(make_item(ROW_EDGE_PLAIN, 16'h6060, 16'h4060, 16'h5070, 16'h3030, 16'h9090,
                    16'h5070, 16'h7050, 16'h6666, 16'h4080, 8'h61));
    req_bus.valid = 1'b0;
    run_random(150);

    // Random weight settings.
    repeat (3) begin
      w = random_weights(1'($urandom_range(0, 1)));
      program_weights(w);
      run_random(100);
    end

    // Back to the reset values.
    w = '{use_alt: 1'b0, sp_near_coef: SpNearRst, sp_far_coef: SpFarRst,
          lf_near_coef: LfNearRst, lf_far_coef: LfFarRst,
          hf_center_coef: HfCenterRst, hf_mid_coef: HfMidRst, hf_outer_coef: HfOuterRst};
    program_weights(w);
    run_random(50);

    // Drain and give the verdict.
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
